@@ rtl/core/lcr_pkg.sv @@
// shared types and constants for the largest cool rectangle core
`timescale 1ns / 1ps

package lcr_pkg;

    localparam int unsigned VAL_W     = 16;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned AREA_W    = 21;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 8'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EVAL = 6'b000100,
        S_POP  = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // control from the sequencer to the area unit
    typedef struct packed {
        logic start;
        logic clear;
    } t_area_ctl;

endpackage

@@ rtl/core/lcr_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module lcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lcr_area.sv @@
// shared area unit: width times height plus one, saturate, keep the maximum
`timescale 1ns / 1ps

module lcr_area
    import lcr_pkg::*;
#(
    parameter int CW1 = 11,
    parameter int HW  = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_area_ctl         i_ctl,
    input  logic [CW1-1:0]    i_width,
    input  logic [HW-1:0]     i_height,
    output logic [AREA_W-1:0] o_best
);

    localparam int PW  = CW1 + HW + 1;
    localparam int PW2 = (PW > AREA_W) ? PW : AREA_W;

    logic [PW-1:0]     r_prod;
    logic              r_pend;
    logic [AREA_W-1:0] r_best;
    logic [PW2-1:0]    prod_ext;
    logic [AREA_W-1:0] area_sat;

    always_comb begin
        prod_ext = PW2'(r_prod);
        if (prod_ext > PW2'(AREA_MAX)) begin
            area_sat = AREA_MAX;
        end else begin
            area_sat = prod_ext[AREA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_prod <= PW'(i_width) * PW'({1'b0, i_height} + 1'b1);
        end
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_best <= '0;
        end else begin
            // a zero height offers nothing
            r_pend <= i_ctl.start && (i_height != '0);
            if (i_ctl.clear) begin
                r_best <= '0;
            end else if (r_pend && (area_sat > r_best)) begin
                r_best <= area_sat;
            end
        end
    end

    assign o_best = r_best;

endmodule

@@ rtl/core/largest_cool_rectangle_stream_core.sv @@
// top level: largest all-cool rectangle over a streamed matrix
`timescale 1ns / 1ps

// channel      | direction | signals                      | beat holds
// -------------+-----------+------------------------------+----------------------------
// s_axis       | in        | tvalid tready tdata[15:0]    | cell_value, row-major order
// m_axis       | out       | tvalid tready tdata[23:0]    | best_area in bits 20:0
// cfg          | in        | valid ready index[7:0] data  | num_rows (0), num_cols (1)
//
// each value steps through accept, ram read, evaluate and finish, plus a pop-or-push
// step per stack push and a pop-or-push and a multiply step per stack pop; the pop
// loop through the shared area multiplier and the stack ram's registered read sets
// the cost, and a row's stack is flushed through the same loop at its last column
// synchronous active-low reset clears control state only; rams need no clearing
// input and config are not ready while a value is in flight; the single result
// sits in an output register, and the block stalls at the last value only if
// the previous result has still not been taken

module largest_cool_rectangle_stream_core
    import lcr_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // [15:0] cell_value
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [23:0]          o_m_axis_tdata,   // [20:0] best_area, [23:21] zero
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CW1 = $clog2(MAX_COLS + 1);
    localparam int DW  = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RW1 = $clog2(MAX_ROWS + 1);
    localparam int HW  = $clog2(MAX_ROWS);
    localparam int SW  = CW + HW;
    localparam int ROWS_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
    localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;

    t_state r_state, n_state;

    // dimensions, already clamped
    logic [RW1-1:0] r_rows;
    logic [CW1-1:0] r_cols;

    // position and per-value datapath
    logic [RW-1:0]    r_r;
    logic [CW-1:0]    r_c;
    logic [VAL_W-1:0] r_v;
    logic [VAL_W-1:0] r_left;
    logic [VAL_W-1:0] r_tl;
    logic [HW-1:0]    r_h;
    logic [CW-1:0]    r_lpos;

    // stack: top entry in flops, the rest in ram
    logic [DW-1:0] r_depth;
    logic [CW-1:0] r_top_pos;
    logic [HW-1:0] r_top_h;
    logic          r_flush;

    // result register
    logic              r_ovalid;
    logic [AREA_W-1:0] r_odata;

    logic              cfg_acc;
    logic              in_acc;
    logic [RW1-1:0]    rows_cl;
    logic [CW1-1:0]    cols_cl;
    logic [CW1-1:0]    cols_m1;
    logic [CW-1:0]     last_col;
    logic [CW-1:0]     j;
    logic              at_last_col;
    logic              window;
    logic              emit;
    logic              fin_go;
    logic              do_pop;
    logic [DW-1:0]     depth_m1;
    logic [DW-1:0]     depth_m2;
    logic [RW1-1:0]    r_p1;
    logic signed [16:0] sum_diag;
    logic signed [16:0] sum_anti;
    logic              cool;
    logic [HW-1:0]     h_new;
    logic [CW1-1:0]    pop_width;

    logic             prev_we;
    logic [CW-1:0]    prev_waddr;
    logic [VAL_W-1:0] prev_wdata;
    logic [VAL_W-1:0] prev_rdata;
    logic             hgt_we;
    logic [HW-1:0]    hgt_rdata;
    logic             stk_we;
    logic [SW-1:0]    stk_rdata;

    t_area_ctl         area_ctl;
    logic [AREA_W-1:0] best;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // clamp register writes to the supported range
    always_comb begin
        if (i_cfg_data < CFG_W'(2)) begin
            rows_cl = RW1'(2);
            cols_cl = CW1'(2);
        end else begin
            rows_cl = (int'(i_cfg_data) > MAX_ROWS) ? RW1'(MAX_ROWS) : RW1'(i_cfg_data);
            cols_cl = (int'(i_cfg_data) > MAX_COLS) ? CW1'(MAX_COLS) : CW1'(i_cfg_data);
        end
    end

    assign cols_m1     = r_cols - CW1'(1);
    assign last_col    = cols_m1[CW-1:0];
    assign j           = r_c - CW'(1);
    assign at_last_col = (r_c == last_col);
    assign window      = (r_c != '0) && (r_r != '0);
    assign r_p1        = RW1'(r_r) + RW1'(1);
    assign emit        = at_last_col && (r_p1 == r_rows);
    assign fin_go      = (r_state == S_FIN) && !(emit && r_ovalid && !i_m_axis_tready);
    assign depth_m1    = r_depth - DW'(1);
    assign depth_m2    = r_depth - DW'(2);
    assign do_pop      = (r_depth != '0) && (r_flush || (r_top_h > r_h));

    // cool test: top-left + bottom-right <= top-right + bottom-left
    assign sum_diag = $signed({r_tl[VAL_W-1], r_tl}) + $signed({r_v[VAL_W-1], r_v});
    assign sum_anti = $signed({prev_rdata[VAL_W-1], prev_rdata})
                    + $signed({r_left[VAL_W-1], r_left});
    assign cool     = (sum_diag <= sum_anti);

    always_comb begin
        if (!cool) begin
            h_new = '0;
        end else if (r_r == RW'(1)) begin
            h_new = HW'(1);
        end else begin
            h_new = hgt_rdata + HW'(1);
        end
    end

    // cells wide: popped run ends at j, or at the last column when flushing
    assign pop_width = CW1'(r_c) - CW1'(r_top_pos) + CW1'(r_flush);

    // ram port control
    always_comb begin
        prev_we    = 1'b0;
        prev_waddr = j;
        prev_wdata = r_left;
        if ((r_state == S_READ) && (r_c != '0)) begin
            prev_we = 1'b1;
        end else if (fin_go && at_last_col) begin
            prev_we    = 1'b1;
            prev_waddr = r_c;
            prev_wdata = r_v;
        end
    end

    assign hgt_we = (r_state == S_EVAL) && window;
    assign stk_we = (r_state == S_POP) && !do_pop && !r_flush && (r_depth != '0);

    assign area_ctl.start = (r_state == S_POP) && do_pop;
    assign area_ctl.clear = cfg_acc || (fin_go && emit);

    lcr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (r_c),
        .o_rdata (prev_rdata)
    );

    lcr_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_hgt_ram (
        .i_clk   (i_clk),
        .i_we    (hgt_we),
        .i_waddr (j),
        .i_wdata (h_new),
        .i_raddr (j),
        .o_rdata (hgt_rdata)
    );

    lcr_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (depth_m1[CW-1:0]),
        .i_wdata ({r_top_pos, r_top_h}),
        .i_raddr (depth_m2[CW-1:0]),
        .o_rdata (stk_rdata)
    );

    lcr_area #(.CW1(CW1), .HW(HW)) u_area (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (area_ctl),
        .i_width  (pop_width),
        .i_height (r_top_h),
        .o_best   (best)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: n_state = window ? S_POP : S_FIN;
            S_POP: begin
                if (do_pop) begin
                    n_state = S_MUL;
                end else if (!r_flush && at_last_col) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: n_state = S_POP;
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_v <= i_s_axis_tdata;
        end
        if (r_state == S_EVAL) begin
            r_tl   <= prev_rdata;
            r_h    <= h_new;
            r_lpos <= j;
        end
        if ((r_state == S_POP) && do_pop) begin
            r_lpos <= r_top_pos;
        end
        if ((r_state == S_POP) && !do_pop && !r_flush) begin
            r_top_pos <= r_lpos;
            r_top_h   <= r_h;
        end
        if ((r_state == S_MUL) && (r_depth != '0)) begin
            {r_top_pos, r_top_h} <= stk_rdata;
        end
        if (fin_go && emit) begin
            r_odata <= best;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rows   <= RW1'(ROWS_RST);
            r_cols   <= CW1'(COLS_RST);
            r_r      <= '0;
            r_c      <= '0;
            r_left   <= '0;
            r_depth  <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_acc) begin
                if (i_cfg_index == CFG_NUM_ROWS) begin
                    r_rows <= rows_cl;
                end
                if (i_cfg_index == CFG_NUM_COLS) begin
                    r_cols <= cols_cl;
                end
                // any write restarts the matrix
                r_r     <= '0;
                r_c     <= '0;
                r_left  <= '0;
                r_depth <= '0;
            end
            if (r_state == S_POP) begin
                if (do_pop) begin
                    r_depth <= depth_m1;
                end else if (!r_flush) begin
                    r_depth <= r_depth + DW'(1);
                    r_flush <= at_last_col;
                end
            end
            if (fin_go) begin
                r_flush <= 1'b0;
                r_left  <= r_v;
                if (at_last_col) begin
                    r_c     <= '0;
                    r_depth <= '0;
                    if (emit) begin
                        r_r      <= '0;
                        r_left   <= '0;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_r <= r_p1[RW-1:0];
                    end
                end else begin
                    r_c <= r_c + CW'(1);
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {3'b000, r_odata};

`ifndef SYNTHESIS
    // stack never holds more entries than window columns in a row
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DW'(r_depth) < DW'(r_cols))
        else $error("stack depth overflow");

    // column position stays inside the row
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW1'(r_c) < r_cols)
        else $error("column counter out of range");

    // a pop always comes from the pop-or-push step
    a_mul_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> ($past(r_state) == S_POP))
        else $error("multiply step without pop");

    // an accepted value starts the ram read
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_READ))
        else $error("accepted value not processed");

    // flush only runs at the row's last column
    a_flush_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> at_last_col)
        else $error("flush away from row end");
`endif

endmodule

@@ verif/largest_cool_rectangle_stream_core_tb.sv @@
// testbench for the largest cool rectangle stream core
`timescale 1ns / 1ps

module largest_cool_rectangle_stream_core_tb;
    import lcr_pkg::*;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_CELLS = 1800;
    localparam int MIN_MATRICES = 60;
    // long settle: room for a row flush that pops every stack entry in turn
    localparam int SETTLE_LONG = 4 * MAX_COLS + 64;
    localparam int SETTLE_SHORT = 16;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN_LIMIT = 200000;
    localparam longint LIMIT_NS = 40_000_000;

    // index values the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_NUM_COLS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum int {
        FILL_RANDOM,
        FILL_PLANE,
        FILL_EXTREME,
        FILL_NARROW
    } t_fill;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata = '0;    // [15:0] cell_value
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [23:0]          o_m_axis_tdata;         // [20:0] best_area, [23:21] zero
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    largest_cool_rectangle_stream_core #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: registers as written, stores and counters
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   rows_reg = 11'd1024;
    logic [CFG_W-1:0]   cols_reg = 11'd1024;
    logic signed [15:0] above_vals [MAX_COLS];   // previous row, per column
    logic signed [15:0] left_val = '0;
    int unsigned        run_len [MAX_COLS];      // cool windows stacked per column
    int unsigned        stk_start [MAX_COLS];
    int unsigned        stk_run [MAX_COLS];
    int unsigned        stk_depth = 0;
    int unsigned        row_pos = 0;
    int unsigned        col_pos = 0;
    int unsigned        best_cells = 0;

    logic [AREA_W-1:0]  area_q [$];              // expected best_area beats
    logic [15:0]        cell_q [$];              // values waiting for the driver
    int                 col_base [MAX_COLS];
    int                 fail_count = 0;
    int                 hold_req = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_matrix();
        stk_depth = 0;
        row_pos = 0;
        col_pos = 0;
        best_cells = 0;
        left_val = '0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        if (idx == CFG_NUM_ROWS) begin
            rows_reg = data;
            restart_matrix();
        end else if (idx == CFG_NUM_COLS) begin
            cols_reg = data;
            restart_matrix();
        end
    endtask

    // a closed rectangle: width in cells, height in windows
    task automatic offer_rect(input int unsigned wide, input int unsigned run);
        longint unsigned cells;
        if (run == 0) return;
        cells = longint'(wide) * (run + 1);
        if (cells > AREA_MAX) cells = AREA_MAX;
        if (cells > best_cells) best_cells = cells;
    endtask

    // one accepted value: update the window heights and the per-row stack
    task automatic absorb_cell(input logic [15:0] raw);
        int unsigned rows, cols, r, c, j, h, lpos, t;
        int sum_main, sum_anti;
        logic signed [15:0] v;
        v = raw;
        rows = clamp_dim(rows_reg, MAX_ROWS);
        cols = clamp_dim(cols_reg, MAX_COLS);
        r = row_pos;
        c = col_pos;
        if (r >= rows || c >= cols) begin
            restart_matrix();
            r = 0;
            c = 0;
        end
        if (c > 0) begin
            j = c - 1;
            if (r > 0) begin
                // window: top-left, top-right from above, bottom-left, bottom-right here
                sum_main = int'(above_vals[j]) + int'(v);
                sum_anti = int'(above_vals[c]) + int'(left_val);
                lpos = j;
                if (sum_main > sum_anti) h = 0;
                else if (r == 1) h = 1;
                else h = run_len[j] + 1;
                run_len[j] = h;
                while (stk_depth > 0 && stk_run[stk_depth - 1] > h) begin
                    t = stk_depth - 1;
                    offer_rect(j - stk_start[t] + 1, stk_run[t]);
                    lpos = stk_start[t];
                    stk_depth = t;
                end
                if (stk_depth < MAX_COLS) begin
                    stk_start[stk_depth] = lpos;
                    stk_run[stk_depth] = h;
                    stk_depth++;
                end
                // row end: everything still open reaches the right edge
                if (c == cols - 1) begin
                    while (stk_depth > 0) begin
                        t = stk_depth - 1;
                        offer_rect(cols - stk_start[t], stk_run[t]);
                        stk_depth = t;
                    end
                end
            end
            above_vals[j] = left_val;
        end
        left_val = v;
        if (c == cols - 1) above_vals[c] = v;
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            stk_depth = 0;
        end
        row_pos = r;
        col_pos = c;
        if (r >= rows) begin
            area_q.push_back(best_cells[AREA_W-1:0]);
            restart_matrix();
        end
    endtask

    // mostly back to back, now and then a long pause
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // ------------------------------------------------------------------
    // input driver: one beat at a time from cell_q, random gaps between beats
    // ------------------------------------------------------------------
    int unsigned send_wait = 0;
    int unsigned send_quiet = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_wait <= 0;
            send_quiet <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                absorb_cell(i_s_axis_tdata);
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // beat still pending, hold it
            end else if (send_wait > 0) begin
                i_s_axis_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (cell_q.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= cell_q.pop_front();
                // occasional stretch with no idling at all
                if (send_quiet > 0) begin
                    send_quiet <= send_quiet - 1;
                    send_wait <= 0;
                end else if ($urandom_range(0, 99) == 0) begin
                    send_quiet <= $urandom_range(100, 300);
                    send_wait <= 0;
                end else begin
                    send_wait <= gap_len();
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    int unsigned take_stall = 0;
    int unsigned take_quiet = 0;
    int          hold_seen = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            take_stall <= 0;
            take_quiet <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            take_stall <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall <= take_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (take_quiet > 0)
                take_quiet <= take_quiet - 1;
            else if ($urandom_range(0, 99) == 0)
                take_quiet <= $urandom_range(100, 400);
            else
                take_stall <= gap_len();
        end
    end

    // result checker: each beat against the oldest expected area
    logic [AREA_W-1:0] area_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (area_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual best_area %0d",
                         $time, o_m_axis_tdata[AREA_W-1:0]);
                fail_count++;
            end else begin
                area_want = area_q.pop_front();
                if (o_m_axis_tdata[AREA_W-1:0] !== area_want) begin
                    $display("%0t: best_area expected %0d actual %0d",
                             $time, area_want, o_m_axis_tdata[AREA_W-1:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[23:AREA_W] !== '0) begin
                    $display("%0t: tdata pad expected 0 actual %b",
                             $time, o_m_axis_tdata[23:AREA_W]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    // everything sent and answered, then let the core finish any row flush
    task automatic wait_idle(input int unsigned settle);
        do @(negedge i_clk);
        while (cell_q.size() != 0 || i_s_axis_tvalid || area_q.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    // 2x2 matrix in row-major order
    task automatic queue_quad(input logic [15:0] tl, input logic [15:0] tr,
                              input logic [15:0] bl, input logic [15:0] br);
        @(negedge i_clk);
        cell_q.push_back(tl);
        cell_q.push_back(tr);
        cell_q.push_back(bl);
        cell_q.push_back(br);
    endtask

    // first n_vals values of a rows x cols matrix; a plane row+col is cool everywhere
    task automatic queue_matrix(input int unsigned rows, input int unsigned cols,
                                input t_fill fill, input int unsigned noise_pct,
                                input int unsigned n_vals);
        int unsigned r, c, n;
        int rb, val;
        @(negedge i_clk);
        n = 0;
        for (c = 0; c < cols; c++) col_base[c] = $urandom_range(0, 32767) - 16384;
        for (r = 0; r < rows; r++) begin
            rb = $urandom_range(0, 32767) - 16384;
            for (c = 0; c < cols; c++) begin
                if (n == n_vals) return;
                case (fill)
                    FILL_PLANE:   val = rb + col_base[c];
                    FILL_EXTREME: val = $urandom_range(0, 1) ? 32767 : -32768;
                    FILL_NARROW:  val = $urandom_range(0, 3) - 2;
                    default:      val = $urandom;
                endcase
                if ($urandom_range(0, 99) < noise_pct) val = $urandom;
                cell_q.push_back(val[15:0]);
                n++;
            end
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(2, 8);
        if (roll < 95) return $urandom_range(9, 40);
        return $urandom_range(0, 1);
    endfunction

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned rows, cols, n_mats, k, sent_vals, done_mats, drain, roll;
        logic [CFG_W-1:0] rows_raw, cols_raw;
        t_fill fill;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a few values at the reset size, never completing a matrix
        @(negedge i_clk);
        cell_q.push_back(16'h8000);
        cell_q.push_back(16'h7fff);
        cell_q.push_back(16'h0000);
        cell_q.push_back(16'hffff);
        cell_q.push_back(16'h0001);
        wait_idle(SETTLE_LONG);

        write_reg(CFG_NUM_ROWS, 11'd2);
        write_reg(CFG_NUM_COLS, 11'd2);
        queue_quad(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // tie counts as cool
        queue_quad(16'h0001, 16'h0000, 16'h0000, 16'h0000);   // one short of cool
        queue_quad(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);   // sums overflow 16 bits
        queue_quad(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        wait_idle(SETTLE_SHORT);

        // writes to indexes with no register must change nothing
        write_reg(CFG_SPARE_LO, 11'd5);
        write_reg(CFG_SPARE_HI, 11'd7);
        queue_quad(16'h0003, 16'h0004, 16'h0005, 16'h0006);
        wait_idle(SETTLE_SHORT);

        // below the legal range: both saturate up to 2
        write_reg(CFG_NUM_ROWS, 11'd0);
        write_reg(CFG_NUM_COLS, 11'd1);
        for (k = 0; k < 4; k++) queue_matrix(2, 2, FILL_RANDOM, 0, 4);
        wait_idle(SETTLE_SHORT);

        // widest matrix, the column count saturating down to the maximum
        write_reg(CFG_NUM_ROWS, 11'd2);
        write_reg(CFG_NUM_COLS, 11'd2047);
        queue_matrix(2, MAX_COLS, FILL_PLANE, 1, 2 * MAX_COLS);
        wait_idle(SETTLE_SHORT);

        // tallest matrix
        write_reg(CFG_NUM_ROWS, 11'd1024);
        write_reg(CFG_NUM_COLS, 11'd2);
        queue_matrix(MAX_ROWS, 2, FILL_PLANE, 1, 2 * MAX_ROWS);
        wait_idle(SETTLE_SHORT);

        // receiver holds off while many small matrices keep arriving
        write_reg(CFG_NUM_ROWS, 11'd3);
        write_reg(CFG_NUM_COLS, 11'd3);
        @(negedge i_clk);
        hold_req = hold_req + 1;
        for (k = 0; k < 25; k++) queue_matrix(3, 3, FILL_PLANE, 10, 9);
        wait_idle(SETTLE_SHORT);

        // random sizes and content, sometimes cut short by a register write
        sent_vals = 0;
        done_mats = 0;
        while (sent_vals < RANDOM_CELLS || done_mats < MIN_MATRICES) begin
            rows_raw = pick_dim();
            cols_raw = pick_dim();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_NUM_ROWS, rows_raw);
                write_reg(CFG_NUM_COLS, cols_raw);
            end else begin
                write_reg(CFG_NUM_COLS, cols_raw);
                write_reg(CFG_NUM_ROWS, rows_raw);
            end
            rows = clamp_dim(rows_raw, MAX_ROWS);
            cols = clamp_dim(cols_raw, MAX_COLS);
            n_mats = $urandom_range(1, 4);
            for (k = 0; k < n_mats; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 35) fill = FILL_PLANE;
                else if (roll < 65) fill = FILL_RANDOM;
                else if (roll < 80) fill = FILL_EXTREME;
                else fill = FILL_NARROW;
                queue_matrix(rows, cols, fill, $urandom_range(0, 15), rows * cols);
                sent_vals += rows * cols;
                done_mats++;
            end
            if ($urandom_range(0, 7) == 0) begin
                // partial matrix: no result, the next write restarts the core
                roll = $urandom_range(1, rows * cols - 1);
                queue_matrix(rows, cols, FILL_PLANE, 5, roll);
                sent_vals += roll;
                wait_idle(SETTLE_LONG);
            end else begin
                wait_idle(SETTLE_SHORT);
            end
        end

        // drain with a bound, then a last look for stray beats
        drain = 0;
        do begin
            @(negedge i_clk);
            drain++;
        end while ((cell_q.size() != 0 || i_s_axis_tvalid || area_q.size() != 0)
                   && drain < DRAIN_LIMIT);
        repeat (SETTLE_LONG) @(negedge i_clk);
        if (area_q.size() != 0) begin
            $display("%0t: %0d expected beats never arrived, next expected %0d",
                     $time, area_q.size(), area_q[0]);
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #LIMIT_NS;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ largest_cool_rectangle_stream_core.f @@
rtl/core/lcr_pkg.sv
rtl/core/lcr_ram.sv
rtl/core/lcr_area.sv
rtl/core/largest_cool_rectangle_stream_core.sv
verif/largest_cool_rectangle_stream_core_tb.sv
